// ===== hw/rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register indexes and item types for the ray/sphere test.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned RAD_W     = 31;
  localparam int unsigned A_W       = 64;
  localparam int unsigned NH_W      = 65;
  localparam int unsigned CC_W      = 66;
  localparam int unsigned DISC_W    = 130;
  localparam int unsigned ROOT_W    = DISC_W / 2;
  localparam int unsigned SREM_W    = ROOT_W + 2;
  localparam int unsigned Q_W       = 31;
  localparam int unsigned NUM_W     = NH_W + FRAC_BITS;
  localparam int unsigned NTOP_W    = NUM_W - Q_W;
  localparam int unsigned FRONT_LAT = 7;
  localparam int unsigned PIPE_LAT  = FRONT_LAT + ROOT_W + 2 + Q_W + 2;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  typedef struct packed {
    logic [2:0][IN_W-1:0] org;
    logic [2:0][IN_W-1:0] dir;
  } rsi_ray_t;

  typedef struct packed {
    logic            live;
    logic            sat;
    logic [A_W-1:0]  a;
    logic [NH_W-1:0] negh;
    rsi_ray_t        ray;
  } rsi_tag_t;

endpackage

// ===== hw/rtl/ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Throughput: one item per cycle; busy never rises, results cannot be stalled.
// Items pass rsi_front, the 65-cell root chain, 31-cell divider and rsi_back.
// Reset: clears all valid bits and loads centre 0 and radius 1.0.
// ----------------------------------------------------------------------------
module ray_sphere_intersect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [rsi_pkg::IN_W-1:0] origin_x_i,
  input  logic signed [rsi_pkg::IN_W-1:0] origin_y_i,
  input  logic signed [rsi_pkg::IN_W-1:0] origin_z_i,
  input  logic signed [rsi_pkg::IN_W-1:0] dir_x_i,
  input  logic signed [rsi_pkg::IN_W-1:0] dir_y_i,
  input  logic signed [rsi_pkg::IN_W-1:0] dir_z_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [rsi_pkg::IN_W-1:0]        cfg_data_i,
  output logic                            done_o,
  output logic                            is_hit_o,
  output logic [rsi_pkg::RAD_W-1:0]       hit_distance_o,
  output logic signed [rsi_pkg::IN_W-1:0] point_x_o,
  output logic signed [rsi_pkg::IN_W-1:0] point_y_o,
  output logic signed [rsi_pkg::IN_W-1:0] point_z_o
);
  import rsi_pkg::*;

  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(1) << FRAC_BITS;

  logic                 acc;
  rsi_ray_t             ray_in;
  logic [2:0][IN_W-1:0] cen_q;
  logic [RAD_W-1:0]     rad_q;

  logic              sq_vld  [ROOT_W+1];
  rsi_tag_t          sq_tag  [ROOT_W+1];
  logic [DISC_W-1:0] sq_rad  [ROOT_W+1];
  logic [SREM_W-1:0] sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];

  logic              d0_vld_q, d1_vld_q;
  rsi_tag_t          d0_tag_q;
  logic [NUM_W-1:0]  d0_num_q;
  logic [NH_W-1:0]   e_w;
  logic [A_W-1:0]    ntop_w;
  logic              sat_w;

  logic              dv_vld [Q_W+1];
  rsi_tag_t          dv_tag [Q_W+1];
  logic [Q_W-1:0]    dv_num [Q_W+1];
  logic [A_W-1:0]    dv_rem [Q_W+1];
  logic [Q_W-1:0]    dv_quo [Q_W+1];

  logic [2:0][IN_W-1:0] pt;

  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign ray_in = '{org: {origin_z_i, origin_y_i, origin_x_i},
                    dir: {dir_z_i, dir_y_i, dir_x_i}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= '0;
      rad_q <= RAD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X: cen_q[0] <= cfg_data_i;
        REG_CENTER_Y: cen_q[1] <= cfg_data_i;
        REG_CENTER_Z: cen_q[2] <= cfg_data_i;
        REG_RADIUS:   rad_q    <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  rsi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (acc),
    .ray_i  (ray_in),
    .cen_i  (cen_q),
    .rad_i  (rad_q),
    .vld_o  (sq_vld[0]),
    .tag_o  (sq_tag[0]),
    .disc_o (sq_rad[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    rsi_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (sq_vld[i]),
      .tag_i  (sq_tag[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .vld_o  (sq_vld[i+1]),
      .tag_o  (sq_tag[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // numerator (-H - S) scaled, then range check against the quotient width
  assign e_w    = sq_tag[ROOT_W].negh - sq_root[ROOT_W];
  assign ntop_w = A_W'(d0_num_q[NUM_W-1 -: NTOP_W]);
  assign sat_w  = ntop_w >= d0_tag_q.a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_vld_q <= 1'b0;
      d1_vld_q <= 1'b0;
    end else begin
      d0_vld_q <= sq_vld[ROOT_W];
      d1_vld_q <= d0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_tag_q  <= sq_tag[ROOT_W];
    d0_num_q  <= {e_w, {FRAC_BITS{1'b0}}};
    dv_tag[0] <= '{live: d0_tag_q.live, sat: sat_w, a: d0_tag_q.a,
                   negh: d0_tag_q.negh, ray: d0_tag_q.ray};
    dv_num[0] <= d0_num_q[Q_W-1:0];
    dv_rem[0] <= sat_w ? '0 : ntop_w;
  end

  assign dv_vld[0] = d1_vld_q;
  assign dv_quo[0] = '0;

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    rsi_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (dv_vld[i]),
      .tag_i  (dv_tag[i]),
      .num_i  (dv_num[i]),
      .rem_i  (dv_rem[i]),
      .quo_i  (dv_quo[i]),
      .vld_o  (dv_vld[i+1]),
      .tag_o  (dv_tag[i+1]),
      .num_o  (dv_num[i+1]),
      .rem_o  (dv_rem[i+1]),
      .quo_o  (dv_quo[i+1])
    );
  end

  rsi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vld_i          (dv_vld[Q_W]),
    .tag_i          (dv_tag[Q_W]),
    .quo_i          (dv_quo[Q_W]),
    .done_o         (done_o),
    .is_hit_o       (is_hit_o),
    .hit_distance_o (hit_distance_o),
    .point_o        (pt)
  );

  assign point_x_o = pt[0];
  assign point_y_o = pt[1];
  assign point_z_o = pt[2];

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##PIPE_LAT done_o)
    else $error("item result missing at expected latency");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !is_hit_o |-> hit_distance_o == '0 && point_x_o == '0 &&
                            point_y_o == '0 && point_z_o == '0)
    else $error("miss item carries non-zero fields");

endmodule

// ===== hw/rtl/rsi_front.sv =====
// ----------------------------------------------------------------------------
// rsi_front
// Quadratic set-up: dot products, hit pre-checks and the discriminant.
// ----------------------------------------------------------------------------
module rsi_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              vld_i,
  input  rsi_pkg::rsi_ray_t                 ray_i,
  input  logic [2:0][rsi_pkg::IN_W-1:0]     cen_i,
  input  logic [rsi_pkg::RAD_W-1:0]         rad_i,
  output logic                              vld_o,
  output rsi_pkg::rsi_tag_t                 tag_o,
  output logic [rsi_pkg::DISC_W-1:0]        disc_o
);
  import rsi_pkg::*;

  logic     vld_q [FRONT_LAT];
  rsi_ray_t ray_q [FRONT_LAT];

  // s1
  logic signed [32:0] p1_q [3];
  // s2
  logic signed [64:0] pd2_q [3];
  logic [64:0]        pp2_q [3];
  logic [63:0]        dd2_q [3];
  logic [61:0]        rr2_q;
  logic signed [64:0] pd_w [3];
  logic signed [65:0] pp_w [3];
  logic signed [63:0] dd_w [3];
  // s3
  logic [A_W-1:0]     a3_q;
  logic signed [66:0] h3_q;
  logic [66:0]        pp3_q;
  logic [61:0]        rr3_q;
  // s4
  logic signed [66:0] nh_full;
  logic [66:0]        cc_full;
  logic               live4_q, live5_q, live6_q, live7_q;
  logic [A_W-1:0]     a4_q, a5_q, a6_q, a7_q;
  logic [NH_W-1:0]    negh4_q, negh5_q, negh6_q, negh7_q;
  logic [CC_W-1:0]    cc4_q;
  // s5
  logic [63:0]        hh5_q;
  logic [64:0]        hl5_q;
  logic [65:0]        ll5_q;
  logic [64:0]        ahch5_q, ahcl5_q, alch5_q;
  logic [64:0]        alcl5_q;
  // s6
  logic [DISC_W-1:0]  h2_d, ac_d, h2_q, ac_q;
  // s7
  logic [DISC_W:0]    dd_full;
  logic [DISC_W-1:0]  disc7_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pd_w[k] = p1_q[k] * $signed(ray_q[0].dir[k]);
      pp_w[k] = p1_q[k] * p1_q[k];
      dd_w[k] = $signed(ray_q[0].dir[k]) * $signed(ray_q[0].dir[k]);
    end
  end

  assign nh_full = -h3_q;
  assign cc_full = pp3_q - 67'(rr3_q);

  assign h2_d = (DISC_W'(hh5_q) << 66) + (DISC_W'(hl5_q) << 34) + DISC_W'(ll5_q);
  assign ac_d = (DISC_W'(ahch5_q) << 65) + (DISC_W'(ahcl5_q) << 32)
              + (DISC_W'(alch5_q) << 33) + DISC_W'(alcl5_q);
  assign dd_full = {1'b0, h2_q} - {1'b0, ac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRONT_LAT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < FRONT_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ray_q[0] <= ray_i;
    for (int i = 1; i < FRONT_LAT; i++) ray_q[i] <= ray_q[i-1];
    for (int k = 0; k < 3; k++) begin
      p1_q[k]  <= 33'($signed(ray_i.org[k])) - 33'($signed(cen_i[k]));
      pd2_q[k] <= pd_w[k];
      pp2_q[k] <= pp_w[k][64:0];
      dd2_q[k] <= dd_w[k];
    end
    rr2_q   <= rad_i * rad_i;
    a3_q    <= dd2_q[0] + dd2_q[1] + dd2_q[2];
    h3_q    <= 67'(pd2_q[0]) + 67'(pd2_q[1]) + 67'(pd2_q[2]);
    pp3_q   <= 67'(pp2_q[0]) + 67'(pp2_q[1]) + 67'(pp2_q[2]);
    rr3_q   <= rr2_q;
    live4_q <= (a3_q != '0) && (nh_full > 0) && (pp3_q >= 67'(rr3_q));
    a4_q    <= a3_q;
    negh4_q <= nh_full[NH_W-1:0];
    cc4_q   <= cc_full[CC_W-1:0];
    hh5_q   <= negh4_q[64:33] * negh4_q[64:33];
    hl5_q   <= negh4_q[64:33] * negh4_q[32:0];
    ll5_q   <= negh4_q[32:0] * negh4_q[32:0];
    ahch5_q <= a4_q[63:32] * cc4_q[65:33];
    ahcl5_q <= a4_q[63:32] * cc4_q[32:0];
    alch5_q <= a4_q[31:0] * cc4_q[65:33];
    alcl5_q <= a4_q[31:0] * cc4_q[31:0] + ((a4_q[31:0] * cc4_q[32]) << 32);
    live5_q <= live4_q;
    a5_q    <= a4_q;
    negh5_q <= negh4_q;
    h2_q    <= h2_d;
    ac_q    <= ac_d;
    live6_q <= live5_q;
    a6_q    <= a5_q;
    negh6_q <= negh5_q;
    live7_q <= live6_q && !dd_full[DISC_W] && (dd_full != '0);
    disc7_q <= dd_full[DISC_W-1:0];
    a7_q    <= a6_q;
    negh7_q <= negh6_q;
  end

  assign vld_o  = vld_q[FRONT_LAT-1];
  assign disc_o = disc7_q;
  assign tag_o  = '{live: live7_q, sat: 1'b0, a: a7_q, negh: negh7_q,
                    ray: ray_q[FRONT_LAT-1]};

endmodule

// ===== hw/rtl/rsi_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rsi_sqrt_cell
// One root bit of the restoring integer square root.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  rsi_pkg::rsi_tag_t            tag_i,
  input  logic [rsi_pkg::DISC_W-1:0]   rad_i,
  input  logic [rsi_pkg::SREM_W-1:0]   rem_i,
  input  logic [rsi_pkg::ROOT_W-1:0]   root_i,
  output logic                         vld_o,
  output rsi_pkg::rsi_tag_t            tag_o,
  output logic [rsi_pkg::DISC_W-1:0]   rad_o,
  output logic [rsi_pkg::SREM_W-1:0]   rem_o,
  output logic [rsi_pkg::ROOT_W-1:0]   root_o
);
  import rsi_pkg::*;

  logic [SREM_W+1:0] rem_sh, trial, diff;
  logic              fit;
  logic              vld_q;
  rsi_tag_t          tag_q;
  logic [DISC_W-1:0] rad_q;
  logic [SREM_W-1:0] rem_q;
  logic [ROOT_W-1:0] root_q;

  assign rem_sh = {rem_i, rad_i[DISC_W-1 -: 2]};
  assign trial  = {2'b00, root_i, 2'b01};
  assign diff   = rem_sh - trial;
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_i;
    rad_q  <= {rad_i[DISC_W-3:0], 2'b00};
    rem_q  <= fit ? diff[SREM_W-1:0] : rem_sh[SREM_W-1:0];
    root_q <= {root_i[ROOT_W-2:0], fit};
  end

  assign vld_o  = vld_q;
  assign tag_o  = tag_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/rsi_div_cell.sv =====
// ----------------------------------------------------------------------------
// rsi_div_cell
// One quotient bit of the restoring divider for the hit distance.
// ----------------------------------------------------------------------------
module rsi_div_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  rsi_pkg::rsi_tag_t          tag_i,
  input  logic [rsi_pkg::Q_W-1:0]    num_i,
  input  logic [rsi_pkg::A_W-1:0]    rem_i,
  input  logic [rsi_pkg::Q_W-1:0]    quo_i,
  output logic                       vld_o,
  output rsi_pkg::rsi_tag_t          tag_o,
  output logic [rsi_pkg::Q_W-1:0]    num_o,
  output logic [rsi_pkg::A_W-1:0]    rem_o,
  output logic [rsi_pkg::Q_W-1:0]    quo_o
);
  import rsi_pkg::*;

  logic [A_W:0]   rem_sh, diff;
  logic           fit;
  logic           vld_q;
  rsi_tag_t       tag_q;
  logic [Q_W-1:0] num_q, quo_q;
  logic [A_W-1:0] rem_q;

  assign rem_sh = {rem_i, num_i[Q_W-1]};
  assign diff   = rem_sh - {1'b0, tag_i.a};
  assign fit    = rem_sh >= {1'b0, tag_i.a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_i;
    num_q <= {num_i[Q_W-2:0], 1'b0};
    rem_q <= fit ? diff[A_W-1:0] : rem_sh[A_W-1:0];
    quo_q <= {quo_i[Q_W-2:0], fit};
  end

  assign vld_o = vld_q;
  assign tag_o = tag_q;
  assign num_o = num_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// ===== hw/rtl/rsi_back.sv =====
// ----------------------------------------------------------------------------
// rsi_back
// Intersection point, saturation and the result register.
// ----------------------------------------------------------------------------
module rsi_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  rsi_pkg::rsi_tag_t            tag_i,
  input  logic [rsi_pkg::Q_W-1:0]      quo_i,
  output logic                         done_o,
  output logic                         is_hit_o,
  output logic [rsi_pkg::RAD_W-1:0]    hit_distance_o,
  output logic [2:0][rsi_pkg::IN_W-1:0] point_o
);
  import rsi_pkg::*;

  localparam logic signed [64:0] PT_MAX = 65'sd2147483647;
  localparam logic signed [64:0] PT_MIN = -65'sd2147483648;

  logic [Q_W-1:0]       q_eff, q1_q;
  logic signed [63:0]   prod_w [3];
  logic signed [63:0]   prod1_q [3];
  logic [2:0][IN_W-1:0] org1_q;
  logic                 vld1_q, live1_q;
  logic signed [64:0]   sum_w [3];
  logic [2:0][IN_W-1:0] pt_w;
  logic                 done_q, hit_q;
  logic [RAD_W-1:0]     dist_q;
  logic [2:0][IN_W-1:0] pt_q;

  assign q_eff = tag_i.sat ? '1 : quo_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_w[k] = $signed({1'b0, q_eff}) * $signed(tag_i.ray.dir[k]);
      sum_w[k]  = 65'($signed(org1_q[k])) + 65'(prod1_q[k] >>> FRAC_BITS);
      if (sum_w[k] > PT_MAX) begin
        pt_w[k] = PT_MAX[IN_W-1:0];
      end else if (sum_w[k] < PT_MIN) begin
        pt_w[k] = PT_MIN[IN_W-1:0];
      end else begin
        pt_w[k] = sum_w[k][IN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      done_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q    <= q_eff;
    live1_q <= tag_i.live;
    org1_q  <= tag_i.ray.org;
    for (int k = 0; k < 3; k++) prod1_q[k] <= prod_w[k];
    hit_q  <= live1_q;
    dist_q <= live1_q ? q1_q : '0;
    pt_q   <= live1_q ? pt_w : '0;
  end

  assign done_o         = done_q;
  assign is_hit_o       = hit_q;
  assign hit_distance_o = dist_q;
  assign point_o        = pt_q;

endmodule

// ===== bench/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// rsi_checker
// Watches the ray and config ports of ray_sphere_intersect. For every ray it
// takes, it works out the expected hit result by exact wide arithmetic and
// queues it. Each result the block returns is compared with the oldest entry.
// ----------------------------------------------------------------------------
module rsi_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  rsi_pkg::rsi_ray_t               ray_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [rsi_pkg::IN_W-1:0]        cfg_data_i,
  input  logic                            done_i,
  input  logic                            is_hit_i,
  input  logic [rsi_pkg::RAD_W-1:0]       hit_distance_i,
  input  logic signed [rsi_pkg::IN_W-1:0] point_x_i,
  input  logic signed [rsi_pkg::IN_W-1:0] point_y_i,
  input  logic signed [rsi_pkg::IN_W-1:0] point_z_i,
  output int                              pending_o,
  output int                              fails_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  typedef logic signed [255:0] wint_t;

  typedef struct packed {
    logic                   hit;
    logic [RAD_W-1:0]       hit_dist;
    logic signed [IN_W-1:0] px;
    logic signed [IN_W-1:0] py;
    logic signed [IN_W-1:0] pz;
  } hit_res_t;

  logic [2:0][IN_W-1:0] centre;
  logic [RAD_W-1:0]     radius;
  hit_res_t             hits_due[$];

  function automatic hit_res_t trace_ray(rsi_ray_t ray);
    hit_res_t res;
    wint_t a, h, c, p, d, disc, s, cand, num, q, pt;
    int k, b;
    res = '0;
    a = 0;
    h = 0;
    c = 0;
    for (k = 0; k < 3; k++) begin
      p = wint_t'(signed'(ray.org[k])) - wint_t'(signed'(centre[k]));
      d = wint_t'(signed'(ray.dir[k]));
      a += d * d;
      h += p * d;
      c += p * p;
    end
    c -= wint_t'(radius) * wint_t'(radius);
    if (a == 0 || h >= 0 || c < 0) return res;
    disc = h * h - a * c;
    if (disc <= 0) return res;
    s = 0;
    for (b = 66; b >= 0; b--) begin
      cand = s | (wint_t'(1) << b);
      if (cand * cand <= disc) s = cand;
    end
    num = (-h - s) <<< FRAC_BITS;
    q = num / a;
    if (q > wint_t'(32'h7FFF_FFFF)) q = wint_t'(32'h7FFF_FFFF);
    res.hit      = 1'b1;
    res.hit_dist = q[RAD_W-1:0];
    for (k = 0; k < 3; k++) begin
      pt = wint_t'(signed'(ray.org[k])) + ((q * wint_t'(signed'(ray.dir[k]))) >>> FRAC_BITS);
      if (pt > wint_t'(32'sh7FFF_FFFF)) pt = wint_t'(32'sh7FFF_FFFF);
      if (pt < wint_t'(-64'sh8000_0000)) pt = wint_t'(-64'sh8000_0000);
      if (k == 0) res.px = pt[IN_W-1:0];
      else if (k == 1) res.py = pt[IN_W-1:0];
      else res.pz = pt[IN_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_res_t got, want;
    if (!rst_ni) begin
      centre  <= '0;
      radius  <= RAD_W'(1 << FRAC_BITS);
      fails_o <= 0;
      hits_due.delete();
    end else begin
      if (start_i && !busy_i) hits_due.push_back(trace_ray(ray_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER_X: centre[0] <= cfg_data_i;
          REG_CENTER_Y: centre[1] <= cfg_data_i;
          REG_CENTER_Z: centre[2] <= cfg_data_i;
          REG_RADIUS:   radius    <= cfg_data_i[RAD_W-1:0];
          default: ;
        endcase
      end
      if (done_i) begin
        got = '{is_hit_i, hit_distance_i, point_x_i, point_y_i, point_z_i};
        if (hits_due.size() == 0) begin
          if (fails_o < 10) $display("unexpected item: %p", got);
          fails_o <= fails_o + 1;
        end else begin
          want = hits_due.pop_front();
          if (got !== want) begin
            if (fails_o < 10) begin
              $display("item wrong: exp hit %b t %h p %h %h %h", want.hit, want.hit_dist,
                       want.px, want.py, want.pz);
              $display("            got hit %b t %h p %h %h %h", got.hit, got.hit_dist,
                       got.px, got.py, got.pz);
            end
            fails_o <= fails_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = hits_due.size();
endmodule

// ===== bench/tb_ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect
// Drives directed and random rays through several sphere settings and idle
// patterns; rsi_checker predicts and compares every item.
// ----------------------------------------------------------------------------
module tb_ray_sphere_intersect;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  localparam int ONE = 1 << FRAC_BITS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  rsi_ray_t ray = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_CENTER_X;
  logic [IN_W-1:0] cfg_data = '0;
  logic done, is_hit;
  logic [RAD_W-1:0] hit_distance;
  logic signed [IN_W-1:0] point_x, point_y, point_z;
  int pending, fails;
  int idle_pct;
  int cen[3];

  always #4 clk_i = ~clk_i;

  ray_sphere_intersect u_top (
    .clk_i, .rst_ni, .start, .busy,
    .origin_x_i(ray.org[0]), .origin_y_i(ray.org[1]), .origin_z_i(ray.org[2]),
    .dir_x_i(ray.dir[0]), .dir_y_i(ray.dir[1]), .dir_z_i(ray.dir[2]),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .done_o(done), .is_hit_o(is_hit), .hit_distance_o(hit_distance),
    .point_x_o(point_x), .point_y_o(point_y), .point_z_o(point_z)
  );

  rsi_checker u_chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .ray_i(ray),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .done_i(done), .is_hit_i(is_hit), .hit_distance_i(hit_distance),
    .point_x_i(point_x), .point_y_i(point_y), .point_z_i(point_z),
    .pending_o(pending), .fails_o(fails)
  );

  task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    ray   <= '{org: '{oz, oy, ox}, dir: '{dz, dy, dx}};
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic set_sphere(int cx, int cy, int cz, int r);
    int vals[4];
    vals = '{cx, cy, cz, r};
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    cen = '{cx, cy, cz};
  endtask

  task automatic random_ray();
    int off[3], d[3], sh;
    if ($urandom_range(99) < 75) begin
      sh = $urandom_range(4, 18);
      for (int k = 0; k < 3; k++) begin
        off[k] = $signed($urandom) >>> sh;
        d[k]   = -(off[k] >>> $urandom_range(0, 6)) + $signed($urandom_range(0, 511)) - 256;
      end
      if ($urandom_range(19) == 0) d = '{0, 0, 0};
      send_ray(cen[0] + off[0], cen[1] + off[1], cen[2] + off[2], d[0], d[1], d[2]);
    end else begin
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    #5ms;
    $display("ray_sphere_intersect: mismatch");
    $finish;
  end

  initial begin
    int pcts[4];
    pcts = '{0, 69, 0, 27};
    cen = '{0, 0, 0};
    idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sphere: unit radius at the origin
    send_ray(-3 * ONE, 0, 0, ONE, 0, 0);
    send_ray(0, -3 * ONE, 0, 0, 2 * ONE, 0);
    send_ray(0, 0, -5 * ONE, 0, 0, ONE / 4);
    send_ray(-3 * ONE, 0, 0, 0, 0, 0);
    send_ray(-2 * ONE, ONE, 0, ONE, 0, 0);
    send_ray(0, 0, 0, ONE, 0, 0);
    send_ray(3 * ONE, 0, 0, ONE, 0, 0);
    send_ray(-32767 * ONE, 0, 0, 1, 0, 0);
    send_ray(-32767 * ONE, 0, 0, -1, 0, 0);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000);
    send_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send_ray(32'h7FFF_FFFF, 0, 0, -1, 0, 0);
    send_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE);
    send_ray(-3 * ONE, 0, 0, -ONE, 0, 0);
    send_ray(-ONE, 0, 0, ONE, 0, 0);
    send_ray(-3 * ONE, 0, 0, 1, 0, 0);
    send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_sphere($signed($urandom) >>> 8, $signed($urandom) >>> 8,
                      $signed($urandom) >>> 8, 1 << 22);
        2: set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF);
        3: set_sphere(0, 0, 0, 0);
        4: set_sphere($signed($urandom) >>> 4, $signed($urandom) >>> 4,
                      $signed($urandom) >>> 4, $urandom_range(ONE, 1 << 27));
        5: set_sphere($urandom, $urandom, $urandom, $urandom & 32'h7FFF_FFFF);
        default: ;
      endcase
      idle_pct = pcts[ph % 4];
      for (int n = 0; n < 325; n++) random_ray();
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (fails == 0) begin
      $display("ray_sphere_intersect: match");
    end else begin
      $display("ray_sphere_intersect: mismatch");
    end
    $finish;
  end
endmodule
